// ===== hdl/stt_pkg.sv =====
// Shared types, token and scan codes, and character class helpers for the
// source text tokenizer. No dependencies.
package stt_pkg;

	localparam int KIND_W  = 5;
	localparam int START_W = 24;
	localparam int LEN_W   = 24;
	localparam int LINE_W  = 20;

	localparam logic [START_W-1:0] START_MAX = '1;
	localparam logic [LINE_W-1:0]  LINE_MAX  = '1;

	// Character codes that the scanner tests against.
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;

	typedef enum logic [KIND_W-1:0] {
		K_LPAREN     = 5'd0,
		K_RPAREN     = 5'd1,
		K_LBRACE     = 5'd2,
		K_RBRACE     = 5'd3,
		K_LBRACKET   = 5'd4,
		K_RBRACKET   = 5'd5,
		K_COMMA      = 5'd6,
		K_COLON      = 5'd7,
		K_DOT        = 5'd8,
		K_MINUS      = 5'd9,
		K_PLUS       = 5'd10,
		K_SEMI       = 5'd11,
		K_STAR       = 5'd12,
		K_SLASH      = 5'd13,
		K_BANG       = 5'd14,
		K_BANG_EQ    = 5'd15,
		K_EQUAL      = 5'd16,
		K_EQUAL_EQ   = 5'd17,
		K_LESS       = 5'd18,
		K_LESS_EQ    = 5'd19,
		K_GREATER    = 5'd20,
		K_GREATER_EQ = 5'd21,
		K_STRING     = 5'd22,
		K_NUMBER     = 5'd23,
		K_IDENT      = 5'd24,
		K_END        = 5'd25,
		K_ERR_CHAR   = 5'd26,
		K_ERR_STR    = 5'd27
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE    = 4'd0,
		S_OP2     = 4'd1,
		S_SLASH   = 4'd2,
		S_COMMENT = 4'd3,
		S_STRING  = 4'd4,
		S_INT     = 4'd5,
		S_DOT     = 4'd6,
		S_FRAC    = 4'd7,
		S_IDENT   = 4'd8
	} scan_state_t;

	typedef struct packed {
		kind_t              kind;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   length;
		logic [LINE_W-1:0]  line;
		logic               last;
	} tok_t;

	// Up to three tokens caused by one item, in order t0, t1, t2.
	typedef struct packed {
		logic [1:0] count;
		tok_t       t2;
		tok_t       t1;
		tok_t       t0;
	} step_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			(c == CH_US);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return c inside {8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h2C, 8'h3A,
			8'h2E, 8'h2D, 8'h2B, 8'h3B, 8'h2A};
	endfunction

	function automatic kind_t punct_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			8'h28:   k = K_LPAREN;
			8'h29:   k = K_RPAREN;
			8'h7B:   k = K_LBRACE;
			8'h7D:   k = K_RBRACE;
			8'h5B:   k = K_LBRACKET;
			8'h5D:   k = K_RBRACKET;
			8'h2C:   k = K_COMMA;
			8'h3A:   k = K_COLON;
			8'h2E:   k = K_DOT;
			8'h2D:   k = K_MINUS;
			8'h2B:   k = K_PLUS;
			8'h3B:   k = K_SEMI;
			8'h2A:   k = K_STAR;
			default: k = K_ERR_CHAR;
		endcase
		return k;
	endfunction

	// Kind of a one-character comparison operator.
	function automatic kind_t op_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_BANG: k = K_BANG;
			CH_EQ:   k = K_EQUAL;
			CH_LT:   k = K_LESS;
			default: k = K_GREATER;
		endcase
		return k;
	endfunction

	// Kind of the same operator followed by an equals sign.
	function automatic kind_t op_eq_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_BANG: k = K_BANG_EQ;
			CH_EQ:   k = K_EQUAL_EQ;
			CH_LT:   k = K_LESS_EQ;
			default: k = K_GREATER_EQ;
		endcase
		return k;
	endfunction

endpackage

// ===== hdl/stt_if.sv =====
// Valid/ready channel interfaces for source characters and tokens.
// Depends on stt_pkg for field widths.
interface stt_char_if import stt_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] char_byte;

	modport source (output valid, output mode, output char_byte, input ready);
	modport sink (input valid, input mode, input char_byte, output ready);
endinterface

interface stt_token_if import stt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  token_kind;
	logic [START_W-1:0] token_start;
	logic [LEN_W-1:0]   token_length;
	logic [LINE_W-1:0]  token_line;
	logic               last_of_run;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output token_line, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_start,
		input token_length, input token_line, input last_of_run, output ready);
endinterface

// ===== hdl/source_text_tokenizer_unit.sv =====
// Top level of the source text tokenizer: input register, scanner, result slots.
// Depends on stt_pkg, stt_if, stt_scanner and stt_result_buf.
//
// The unit takes one source byte (or an end-of-source mark) per cycle while
// the result slots have room, and delivers its tokens through the input
// register and then the result slots. Each item yields zero to three tokens;
// the slots drain one token per cycle while the output is ready, so an item
// that yields several tokens holds the input until they drain, while a run of
// single-token or silent items flows at one item per cycle. The scanner state
// advances once per processed item. No clearing pass follows reset. After an
// end-of-source item every further item is taken and dropped until reset.
module source_text_tokenizer_unit import stt_pkg::*; #(
	parameter int OFFSET_BITS = 24,
	parameter int LINE_BITS   = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	stt_char_if.sink    chars,
	stt_token_if.source tokens
);

	logic       v_s1;
	logic       mode_s1;
	logic [7:0] char_s1;
	logic       room;
	logic       proc;
	step_t      step;
	tok_t       head;
	logic       head_valid;

	// Process the registered item when the result slots can take its tokens.
	always_comb begin
		proc         = v_s1 && room;
		chars.ready  = !v_s1 || room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (chars.ready) begin
			v_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			mode_s1 <= chars.mode;
			char_s1 <= chars.char_byte;
		end
	end

	stt_scanner #(
		.OFFSET_BITS(OFFSET_BITS),
		.LINE_BITS  (LINE_BITS)
	) u_scanner (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (proc),
		.mode  (mode_s1),
		.c     (char_s1),
		.step  (step)
	);

	stt_result_buf u_result_buf (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (proc),
		.step  (step),
		.take  (tokens.ready),
		.head  (head),
		.valid (head_valid),
		.room  (room)
	);

	// Output channel.
	always_comb begin
		tokens.valid        = head_valid;
		tokens.token_kind   = head.kind;
		tokens.token_start  = head.start;
		tokens.token_length = head.length;
		tokens.token_line   = head.line;
		tokens.last_of_run  = head.last;
	end

`ifndef SYNTH
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.token_kind == K_END |-> tokens.last_of_run)
		else $error("end token not marked as last of its run");
`endif

endmodule

// ===== hdl/stt_scanner.sv =====
// Scan state registers and the one-step transition that turns one item into
// up to three tokens. Depends on stt_pkg.
module stt_scanner import stt_pkg::*; #(
	parameter int OFFSET_BITS = 24,
	parameter int LINE_BITS   = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       mode,
	input  logic [7:0] c,
	output step_t      step
);

	// Working width for offsets and lengths, one bit above the widest value.
	localparam int PW = ((OFFSET_BITS > START_W) ? OFFSET_BITS : START_W) + 1;
	localparam int LW = (LINE_BITS > LINE_W) ? LINE_BITS : LINE_W;
	localparam logic [OFFSET_BITS-1:0] OMAX = '1;
	localparam logic [LINE_BITS-1:0]   LMAX = '1;

	scan_state_t            st_q, st_d;
	logic [7:0]             pend_q, pend_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [OFFSET_BITS-1:0] beg_q, beg_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic                   ended_q, ended_d;

	logic [PW-1:0]     p_x, beg_x, len_run, len_str, dot_pos, dot_len;
	logic [LW-1:0]     line_x;
	logic [LINE_W-1:0] line_o;

	tok_t        f0, f1;
	logic [1:0]  fcnt;
	logic        consumed, c_emit, line_inc_c;
	tok_t        ct;
	scan_state_t st_c;
	logic        s_emit, line_inc_s;
	tok_t        s_tok;
	scan_state_t st_s;
	logic [7:0]  pend_s;
	tok_t        a0, a1, x_tok;
	logic [1:0]  a_cnt;
	logic        x_v, line_inc;
	logic [1:0]  cnt;
	tok_t        t0, t1, t2;

	function automatic logic [START_W-1:0] clamp_off(input logic [PW-1:0] v);
		return (v > PW'(START_MAX)) ? START_MAX : v[START_W-1:0];
	endfunction

	function automatic tok_t mk(input kind_t k, input logic [PW-1:0] s,
		input logic [PW-1:0] l, input logic [LINE_W-1:0] ln);
		tok_t t;
		t.kind   = k;
		t.start  = clamp_off(s);
		t.length = clamp_off(l);
		t.line   = ln;
		t.last   = 1'b0;
		return t;
	endfunction

	// Offsets and lengths, with subtraction floored at zero.
	always_comb begin
		p_x     = PW'(pos_q);
		beg_x   = PW'(beg_q);
		len_run = (p_x > beg_x) ? p_x - beg_x : '0;
		len_str = len_run + PW'(1);
		dot_pos = (p_x != '0) ? p_x - PW'(1) : '0;
		dot_len = (dot_pos > beg_x) ? dot_pos - beg_x : '0;
		line_x  = LW'(line_q);
		line_o  = (line_x > LW'(LINE_MAX)) ? LINE_MAX : line_x[LINE_W-1:0];
	end

	// Tokens that close whatever is open.
	always_comb begin
		f0   = mk(K_NUMBER, beg_x, len_run, line_o);
		f1   = mk(K_DOT, dot_pos, PW'(1), line_o);
		fcnt = 2'd0;
		case (st_q)
			S_OP2: begin
				f0   = mk(op_kind(pend_q), beg_x, PW'(1), line_o);
				fcnt = 2'd1;
			end
			S_SLASH: begin
				f0   = mk(K_SLASH, beg_x, PW'(1), line_o);
				fcnt = 2'd1;
			end
			S_STRING: begin
				f0   = mk(K_ERR_STR, beg_x, len_run, line_o);
				fcnt = 2'd1;
			end
			S_INT, S_FRAC: begin
				fcnt = 2'd1;
			end
			S_DOT: begin
				f0   = mk(K_NUMBER, beg_x, dot_len, line_o);
				fcnt = 2'd2;
			end
			S_IDENT: begin
				f0   = mk(K_IDENT, beg_x, len_run, line_o);
				fcnt = 2'd1;
			end
			default: begin
				fcnt = 2'd0;
			end
		endcase
	end

	// Bytes that continue the open token.
	always_comb begin
		consumed   = 1'b0;
		c_emit     = 1'b0;
		line_inc_c = 1'b0;
		st_c       = st_q;
		ct         = mk(K_STRING, beg_x, len_str, line_o);
		case (st_q)
			S_OP2: begin
				if (c == CH_EQ) begin
					consumed = 1'b1;
					c_emit   = 1'b1;
					ct       = mk(op_eq_kind(pend_q), beg_x, PW'(2), line_o);
					st_c     = S_IDLE;
				end
			end
			S_SLASH: begin
				if (c == CH_SLASH) begin
					consumed = 1'b1;
					st_c     = S_COMMENT;
				end
			end
			S_COMMENT: begin
				consumed = 1'b1;
				if (c == CH_NL) begin
					line_inc_c = 1'b1;
					st_c       = S_IDLE;
				end
			end
			S_STRING: begin
				consumed = 1'b1;
				if (c == CH_QUOTE) begin
					c_emit = 1'b1;
					st_c   = S_IDLE;
				end else if (c == CH_NL) begin
					line_inc_c = 1'b1;
				end
			end
			S_INT: begin
				if (is_digit(c)) begin
					consumed = 1'b1;
				end else if (c == CH_DOT) begin
					consumed = 1'b1;
					st_c     = S_DOT;
				end
			end
			S_DOT: begin
				if (is_digit(c)) begin
					consumed = 1'b1;
					st_c     = S_FRAC;
				end
			end
			S_FRAC: begin
				consumed = is_digit(c);
			end
			S_IDENT: begin
				consumed = is_alpha(c) || is_digit(c);
			end
			default: begin
				consumed = 1'b0;
			end
		endcase
	end

	// A byte that opens a new token.
	always_comb begin
		s_emit     = 1'b0;
		line_inc_s = 1'b0;
		st_s       = S_IDLE;
		pend_s     = pend_q;
		s_tok      = mk(K_ERR_CHAR, p_x, PW'(1), line_o);
		if (is_punct(c)) begin
			s_emit = 1'b1;
			s_tok  = mk(punct_kind(c), p_x, PW'(1), line_o);
		end else if (c inside {CH_BANG, CH_EQ, CH_LT, CH_GT}) begin
			st_s   = S_OP2;
			pend_s = c;
		end else if (c == CH_SLASH) begin
			st_s = S_SLASH;
		end else if (c inside {CH_SPACE, CH_CR, CH_TAB}) begin
			st_s = S_IDLE;
		end else if (c == CH_NL) begin
			line_inc_s = 1'b1;
		end else if (c == CH_QUOTE) begin
			st_s = S_STRING;
		end else if (is_digit(c)) begin
			st_s = S_INT;
		end else if (is_alpha(c)) begin
			st_s = S_IDENT;
		end else begin
			s_emit = 1'b1;
		end
	end

	// Choose the path for this item and the next state.
	always_comb begin
		st_d     = st_q;
		pend_d   = pend_q;
		beg_d    = beg_q;
		ended_d  = ended_q;
		pos_d    = pos_q;
		line_inc = 1'b0;
		a0       = f0;
		a1       = f1;
		a_cnt    = 2'd0;
		x_v      = 1'b0;
		x_tok    = s_tok;
		if (!ended_q) begin
			if (mode) begin
				a_cnt   = fcnt;
				x_v     = 1'b1;
				x_tok   = mk(K_END, p_x, '0, line_o);
				st_d    = S_IDLE;
				ended_d = 1'b1;
			end else begin
				pos_d = (pos_q != OMAX) ? pos_q + OFFSET_BITS'(1) : pos_q;
				if (consumed) begin
					x_v      = c_emit;
					x_tok    = ct;
					st_d     = st_c;
					line_inc = line_inc_c;
				end else begin
					a_cnt    = fcnt;
					x_v      = s_emit;
					st_d     = st_s;
					pend_d   = pend_s;
					beg_d    = pos_q;
					line_inc = line_inc_s;
				end
			end
		end
		line_d = (line_inc && (line_q != LMAX)) ? line_q + LINE_BITS'(1) : line_q;
	end

	// Pack the tokens in order and mark the last one.
	always_comb begin
		t0  = a0;
		t1  = a1;
		t2  = x_tok;
		cnt = a_cnt + {1'b0, x_v};
		case (a_cnt)
			2'd0:    t0 = x_tok;
			2'd1:    t1 = x_tok;
			default: t2 = x_tok;
		endcase
		case (cnt)
			2'd1:    t0.last = 1'b1;
			2'd2:    t1.last = 1'b1;
			2'd3:    t2.last = 1'b1;
			default: t0.last = 1'b0;
		endcase
		step.count = cnt;
		step.t0    = t0;
		step.t1    = t1;
		step.t2    = t2;
	end

	// State registers advance once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			pend_q  <= '0;
			pos_q   <= '0;
			beg_q   <= '0;
			line_q  <= LINE_BITS'(1);
			ended_q <= 1'b0;
		end else if (en) begin
			st_q    <= st_d;
			pend_q  <= pend_d;
			pos_q   <= pos_d;
			beg_q   <= beg_d;
			line_q  <= line_d;
			ended_q <= ended_d;
		end
	end

`ifndef SYNTH
	a_end_latches: assert property (@(posedge clk) disable iff (!arst_n)
		en && mode && !ended_q |=> ended_q)
		else $error("end of source did not stop the scanner");
	a_silent_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> step.count == 2'd0)
		else $error("token produced after end of source");
	a_pos_counts: assert property (@(posedge clk) disable iff (!arst_n)
		en && !mode && !ended_q && pos_q != OMAX |=> pos_q == $past(pos_q) + OFFSET_BITS'(1))
		else $error("byte offset did not advance on a source byte");
`endif

endmodule

// ===== hdl/stt_result_buf.sv =====
// Three-slot result register that presents the tokens of one item in order.
// Depends on stt_pkg.
module stt_result_buf import stt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  step_t step,
	input  logic  take,
	output tok_t  head,
	output logic  valid,
	output logic  room
);

	tok_t       slot_q [3];
	logic [1:0] cnt_q;
	logic       pop;

	// New tokens may enter when the slots are empty or their last token leaves this cycle.
	always_comb begin
		valid = (cnt_q != 2'd0);
		pop   = valid && take;
		room  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take);
		head  = slot_q[0];
	end

	// Slot payload: load a fresh set or shift toward the head.
	always_ff @(posedge clk) begin
		if (load) begin
			slot_q[0] <= step.t0;
			slot_q[1] <= step.t1;
			slot_q[2] <= step.t2;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

	// Occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= step.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule
